FILE: design/register_memory_exec_unit_defines.svh
// Assertion macros shared by the execution unit RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef REGISTER_MEMORY_EXEC_UNIT_DEFINES_SVH
`define REGISTER_MEMORY_EXEC_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rme_pkg.sv
// Shared types, constants and helpers for the register/memory execution unit.
// No dependencies; used by rme_exec and register_memory_exec_unit.
package rme_pkg;

    localparam int IDX_W         = 4;
    localparam int DATA_W        = 32;
    localparam int CONST_W       = 27;
    localparam int ACONST_W      = 10;
    localparam int CMD_W         = 3;
    localparam int SHIFT_W       = 5;
    localparam int NUM_REGS_DEF  = 10;
    localparam int MEM_WORDS_DEF = 256;
    localparam int IN_TDATA_W    = 88;
    localparam int OUT_TDATA_W   = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_MOV = 3'd0,
        CMD_LDR = 3'd1,
        CMD_STR = 3'd2,
        CMD_ADD = 3'd3,
        CMD_SUB = 3'd4,
        CMD_LSL = 3'd5,
        CMD_LSR = 3'd6
    } t_cmd;

    // Input beat, last field (command) in the lowest bits
    typedef struct packed {
        logic [ACONST_W-1:0] addr_const;
        logic [IDX_W-1:0]    addr_reg;
        logic                addr_is_reg;
        logic [CONST_W-1:0]  second_const;
        logic [IDX_W-1:0]    second_reg;
        logic                second_is_const;
        logic [CONST_W-1:0]  first_const;
        logic [IDX_W-1:0]    first_reg;
        logic                first_is_const;
        logic [IDX_W-1:0]    dest_reg;
        logic [CMD_W-1:0]    command;
    } t_instr;

    localparam int IN_FIELDS_W  = $bits(t_instr);

    // Result beat, last field (status) in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0] written_value;
        logic [IDX_W-1:0]  written_index;
        logic              reg_written;
        logic              status;
    } t_result;

    localparam int OUT_FIELDS_W = $bits(t_result);

    // A register file write in flight, used for forwarding
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } t_wr;

    // Execute stage outcome handed to the pipeline
    typedef struct packed {
        t_result             res;
        logic                is_load;
        logic                mem_we;
        logic [ACONST_W-1:0] mem_addr;
    } t_exec;

    // Register read on port A: stored register for str, else first source
    function automatic logic [IDX_W-1:0] port_a_idx(t_instr ins);
        if (ins.command == CMD_STR) begin
            return ins.dest_reg;
        end
        return ins.first_reg;
    endfunction

    // Register read on port B: address register for memory ops, else second source
    function automatic logic [IDX_W-1:0] port_b_idx(t_instr ins);
        if (ins.command == CMD_LDR || ins.command == CMD_STR) begin
            return ins.addr_reg;
        end
        return ins.second_reg;
    endfunction

endpackage

FILE: design/register_memory_exec_unit.sv
// Top level of the register/memory execution unit: pipeline, clearing pass, forwarding.
// Depends on rme_pkg, rme_ram, rme_exec and register_memory_exec_unit_defines.svh.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | one decoded instruction per beat
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | one result per instruction
//
// One instruction per cycle while m_axis does not stall; a result passes the input register,
// the execute/memory stage register and the result register before it is offered.
// The register file and data memory read ports are registered RAMs; operands that
// are still in flight come from forwarding of the two newest register writes.
// After reset a clearing pass zeroes both stores while s_axis_tready is low.
// A stall on m_axis freezes the whole pipe; s_axis_tready follows the pipe advance, low while clearing.
`include "register_memory_exec_unit_defines.svh"

module register_memory_exec_unit #(
    parameter int NUM_REGS  = rme_pkg::NUM_REGS_DEF,
    parameter int MEM_WORDS = rme_pkg::MEM_WORDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // command, dest_reg, first_is_const, first_reg, first_const, second_is_const,
    // second_reg, second_const, addr_is_reg, addr_reg, addr_const, zero pad
    input  logic [rme_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status, reg_written, written_index, written_value, zero pad
    output logic [rme_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import rme_pkg::*;

    localparam int RF_AW = $clog2(NUM_REGS);
    localparam int MAW   = $clog2(MEM_WORDS);

    typedef struct packed {
        t_result res;
        logic    is_load;
    } t_s2;

    logic              adv;
    logic              accept;
    t_instr            in_instr;
    logic [IDX_W-1:0]  in_idx_a;
    logic [IDX_W-1:0]  in_idx_b;

    logic              r_s1_valid;
    t_instr            r_s1_instr;
    logic              r_s2_valid;
    t_s2               r_s2;
    logic              r_out_valid;
    t_result           r_out;
    t_wr               r_wb;
    logic              r_clearing;
    logic [MAW-1:0]    r_clr_addr;
    logic [MAW-1:0]    n_clr_addr;

    t_exec             exec;
    t_result           s2_final;
    t_wr               fwd_s2;
    logic [DATA_W-1:0] rf_a_rdata;
    logic [DATA_W-1:0] rf_b_rdata;
    logic [DATA_W-1:0] mem_rdata;

    logic              rf_we;
    logic [RF_AW-1:0]  rf_waddr;
    logic [DATA_W-1:0] rf_wdata;
    logic              mem_we;
    logic [MAW-1:0]    mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // Handshake: the whole pipe moves when the result register is free or drained
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv && !r_clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, r_out};

    // Unpack the incoming beat and pick register read indexes
    always_comb begin
        in_instr = t_instr'(s_axis_tdata[IN_FIELDS_W-1:0]);
        in_idx_a = port_a_idx(in_instr);
        in_idx_b = port_b_idx(in_instr);
    end

    // Stage two result: load data arrives from the memory read register
    always_comb begin
        s2_final = r_s2.res;
        if (r_s2.is_load) begin
            s2_final.written_value = mem_rdata;
        end
        fwd_s2.en    = r_s2_valid && s2_final.reg_written;
        fwd_s2.idx   = s2_final.written_index;
        fwd_s2.value = s2_final.written_value;
    end

    // Register file write: clearing pass, else the stage two write
    always_comb begin
        if (r_clearing) begin
            rf_we    = r_clr_addr < MAW'(NUM_REGS);
            rf_waddr = r_clr_addr[RF_AW-1:0];
            rf_wdata = '0;
        end else begin
            rf_we    = adv && fwd_s2.en;
            rf_waddr = fwd_s2.idx[RF_AW-1:0];
            rf_wdata = fwd_s2.value;
        end
    end

    // Data memory write: clearing pass, else a store leaving the execute stage
    always_comb begin
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = adv && r_s1_valid && exec.mem_we;
            mem_waddr = exec.mem_addr[MAW-1:0];
            mem_wdata = exec.res.written_value;
        end
    end

    assign n_clr_addr = r_clr_addr + MAW'(1);

    // Register file: one copy per read port, written together
    rme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (adv),
        .i_raddr (in_idx_a[RF_AW-1:0]),
        .o_rdata (rf_a_rdata)
    );

    rme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (adv),
        .i_raddr (in_idx_b[RF_AW-1:0]),
        .o_rdata (rf_b_rdata)
    );

    // Data memory
    rme_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (adv),
        .i_raddr (exec.mem_addr[MAW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Execute stage
    rme_exec #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_exec (
        .i_instr  (r_s1_instr),
        .i_rf_a   (rf_a_rdata),
        .i_rf_b   (rf_b_rdata),
        .i_fwd_s2 (fwd_s2),
        .i_fwd_wb (r_wb),
        .o_exec   (exec)
    );

    // Control: valid bits, last register write, clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb        <= '0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= n_clr_addr;
                if (r_clr_addr == MAW'(MEM_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_valid  <= accept;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
                r_wb        <= fwd_s2;
            end
        end
    end

    // Payload: advance with the pipe
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_instr   <= in_instr;
            r_s2.res     <= exec.res;
            r_s2.is_load <= exec.is_load;
            r_out        <= s2_final;
        end
    end

    // Checks
    `RME_ASSERT_IMP(a_clear_idle, r_clearing,
        !r_s1_valid && !r_s2_valid && !r_out_valid, "pipeline busy during clearing pass")
    `RME_ASSERT_NXT(a_wb_follows, adv && fwd_s2.en,
        r_wb.en && (r_wb.idx == $past(fwd_s2.idx)), "last-write register lost a register write")
    `RME_ASSERT_IMP(a_fault_quiet, r_out_valid && r_out.status,
        !r_out.reg_written && (r_out.written_value == '0), "faulting instruction reports a write")
    `RME_ASSERT_IMP(a_wr_in_range, fwd_s2.en,
        fwd_s2.idx < IDX_W'(NUM_REGS), "register write beyond the register file")

endmodule

FILE: design/rme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rme_exec.sv
// Execute stage: operand forwarding, address check, ALU and result forming.
// Depends on rme_pkg.
module rme_exec #(
    parameter int NUM_REGS  = rme_pkg::NUM_REGS_DEF,
    parameter int MEM_WORDS = rme_pkg::MEM_WORDS_DEF
) (
    input  rme_pkg::t_instr                  i_instr,
    input  logic [rme_pkg::DATA_W-1:0]       i_rf_a,
    input  logic [rme_pkg::DATA_W-1:0]       i_rf_b,
    input  rme_pkg::t_wr                     i_fwd_s2,
    input  rme_pkg::t_wr                     i_fwd_wb,
    output rme_pkg::t_exec                   o_exec
);

    import rme_pkg::*;

    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    logic [DATA_W-1:0] reg_a;
    logic [DATA_W-1:0] reg_b;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [DATA_W-1:0] addr;
    logic              fault;
    logic              shift_ok;
    logic              reg_op;
    t_exec             ex;

    // Newest value first: write leaving stage two, then the one just done, then RAM, else zero beyond the file
    function automatic logic [DATA_W-1:0] resolve(
        logic [IDX_W-1:0]  idx,
        logic [DATA_W-1:0] ram,
        t_wr               s2,
        t_wr               wb
    );
        if (s2.en && s2.idx == idx) begin
            return s2.value;
        end
        if (wb.en && wb.idx == idx) begin
            return wb.value;
        end
        if (idx < IDX_W'(NUM_REGS)) begin
            return ram;
        end
        return '0;
    endfunction

    // Operands and address
    always_comb begin
        idx_a    = port_a_idx(i_instr);
        idx_b    = port_b_idx(i_instr);
        reg_a    = resolve(idx_a, i_rf_a, i_fwd_s2, i_fwd_wb);
        reg_b    = resolve(idx_b, i_rf_b, i_fwd_s2, i_fwd_wb);
        op_a     = i_instr.first_is_const ?
                   {{(DATA_W-CONST_W){1'b0}}, i_instr.first_const} : reg_a;
        op_b     = i_instr.second_is_const ?
                   {{(DATA_W-CONST_W){1'b0}}, i_instr.second_const} : reg_b;
        addr     = i_instr.addr_is_reg ?
                   reg_b : {{(DATA_W-ACONST_W){1'b0}}, i_instr.addr_const};
        fault    = addr >= DATA_W'(MEM_WORDS);
        shift_ok = op_b[DATA_W-1:SHIFT_W] == '0;
    end

    // Decode and execute
    always_comb begin
        ex          = '0;
        reg_op      = 1'b0;
        ex.mem_addr = addr[ACONST_W-1:0];
        unique case (t_cmd'(i_instr.command))
            CMD_MOV: begin
                ex.res.written_value = op_a;
                reg_op               = 1'b1;
            end
            CMD_LDR: begin
                if (fault) begin
                    ex.res.status = 1'b1;
                end else begin
                    ex.is_load = 1'b1;
                    reg_op     = 1'b1;
                end
            end
            CMD_STR: begin
                if (fault) begin
                    ex.res.status = 1'b1;
                end else begin
                    ex.mem_we            = 1'b1;
                    ex.res.written_value = reg_a;
                    ex.res.written_index = addr[IDX_W-1:0];
                end
            end
            CMD_ADD: begin
                ex.res.written_value = op_a + op_b;
                reg_op               = 1'b1;
            end
            CMD_SUB: begin
                ex.res.written_value = op_a - op_b;
                reg_op               = 1'b1;
            end
            CMD_LSL: begin
                ex.res.written_value = shift_ok ? (op_a << op_b[SHIFT_W-1:0]) : '0;
                reg_op               = 1'b1;
            end
            CMD_LSR: begin
                ex.res.written_value = shift_ok ? (op_a >> op_b[SHIFT_W-1:0]) : '0;
                reg_op               = 1'b1;
            end
            default: begin
                reg_op = 1'b0;
            end
        endcase
        // Register writes to an index beyond the file are dropped but reported
        if (reg_op) begin
            ex.res.written_index = i_instr.dest_reg;
            ex.res.reg_written   = i_instr.dest_reg < IDX_W'(NUM_REGS);
        end
    end

    assign o_exec = ex;

endmodule
